// File: src/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and codes shared by the frame pacer cells and its top level.
// ----------------------------------------------------------------------------
package fpr_pkg;

   typedef struct packed {
      logic [63:0] stamp;
      logic [7:0]  tag;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   localparam logic [2:0] KIND_ENQUEUED = 3'd0;
   localparam logic [2:0] KIND_FULL     = 3'd1;
   localparam logic [2:0] KIND_SHOW     = 3'd2;
   localparam logic [2:0] KIND_NOTIFY   = 3'd3;
   localparam logic [2:0] KIND_IDLE     = 3'd4;

   localparam logic [1:0] FLAG_NONE      = 2'd0;
   localparam logic [1:0] FLAG_UNLIMITED = 2'd1;
   localparam logic [1:0] FLAG_LIMITED   = 2'd2;

   localparam logic [7:0] CSR_ACTIVE = 8'd0;
   localparam logic [7:0] CSR_ID     = 8'd1;
   localparam logic [7:0] CSR_PERIOD = 8'd2;

   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   localparam int RATE_AFTER_UNLIMITED = 24;
   localparam int RATE_STEP            = 2;
   localparam int RATE_FLOOR           = 2;

endpackage

// File: src/fpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_cell
// One slot of the frame queue: loads an enqueued frame or takes its
// neighbor's frame when the queue advances.
// ----------------------------------------------------------------------------
module fpr_cell (
   input  logic                  clock,
   input  fpr_pkg::cell_ctrl_type ctrl,
   input  fpr_pkg::entry_type    load_word,
   input  fpr_pkg::entry_type    nbr_word,
   output fpr_pkg::entry_type    word
);
   import fpr_pkg::*;

   entry_type word_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         word_ff <= nbr_word;
      end else if (ctrl.load) begin
         word_ff <= load_word;
      end
   end

   assign word = word_ff;

endmodule

// File: src/frame_pacer_rate_feedback_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacer_rate_feedback_top
// Frame queue with timed release and frame rate feedback notifications.
// ----------------------------------------------------------------------------
// An enqueue word is taken while busy is low and its single result appears
// on the next cycle; busy stays low, so enqueues may follow back to back.
// A tick holds busy high while the due frames are released, through the evaluation
// state, and through a notify state as well when both a show and a rate
// notification result are produced: the queue is a row of cells that
// advances one frame per cycle. Results are strobed by rsp_valid for one
// cycle each, the last one flagged by rsp_last; there is no backpressure on
// the result side. The csr port is always ready and should be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module frame_pacer_rate_feedback_top #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int UNLIMITED_RATE = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [63:0] req_time_stamp,
   input  logic [7:0]  req_frame_tag,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_shown_tag,
   output logic [7:0]  rsp_notify_presentation,
   output logic [1:0]  rsp_notify_flags,
   output logic [4:0]  rsp_desired_rate,
   output logic [4:0]  rsp_dropped_in_tick,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import fpr_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int RATE_W = $clog2(UNLIMITED_RATE + 1);
   localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [RATE_W-1:0] UNL_R    = RATE_W'(UNLIMITED_RATE);
   localparam logic [RATE_W-1:0] R_AFTER  = RATE_W'(RATE_AFTER_UNLIMITED);
   localparam logic [RATE_W-1:0] R_STEP   = RATE_W'(RATE_STEP);
   localparam logic [RATE_W-1:0] R_FLOOR  = RATE_W'(RATE_FLOOR);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_NOTE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       drop_total_ff, drop_total_in;
   logic [31:0]       pub_total_ff, pub_total_in;
   logic [63:0]       next_fb_ff, next_fb_in;
   logic [RATE_W-1:0] sent_rate_ff, sent_rate_in;
   logic              active_ff;
   logic [7:0]        pres_id_ff;
   logic [15:0]       period_ff;

   logic [63:0]       now_ff, now_in;
   logic              have_ff, have_in;
   logic [7:0]        tag_ff, tag_in;
   logic [4:0]        drops_ff, drops_in;
   logic [1:0]        note_flags_ff, note_flags_in;
   logic [4:0]        note_rate_ff, note_rate_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_tag_ff, rsp_tag_in;
   logic [7:0]        rsp_pres_ff, rsp_pres_in;
   logic [1:0]        rsp_flags_ff, rsp_flags_in;
   logic [4:0]        rsp_rate_ff, rsp_rate_in;
   logic [4:0]        rsp_drops_ff, rsp_drops_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              enq_ok;
   logic              shift;
   logic              head_due;
   logic [31:0]       pub_next;
   logic              fb_due;
   logic              notify;
   logic [RATE_W-1:0] new_rate;
   logic [RATE_W:0]   rate_sum;

   entry_type         load_word;
   entry_type         words [QUEUE_DEPTH];
   cell_ctrl_type     ctrls [QUEUE_DEPTH];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign enq_ok    = accept && (req_action == ACT_ENQUEUE) && (count_ff != FULL_CNT);
   assign head_due  = (count_ff != '0) && (words[0].stamp <= now_ff);
   assign shift     = (state_ff == ST_DRAIN) && head_due;
   assign load_word = '{stamp: req_time_stamp, tag: req_frame_tag};

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         assign ctrls[gi].shift = shift;
         assign ctrls[gi].load  = enq_ok && (count_ff == CNT_W'(gi));
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            fpr_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrls[gi]),
               .load_word (load_word),
               .nbr_word  (words[gi]),
               .word      (words[gi])
            );
         end else begin : g_body
            fpr_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrls[gi]),
               .load_word (load_word),
               .nbr_word  (words[gi+1]),
               .word      (words[gi])
            );
         end
      end
   endgenerate

   // rate adaptation
   always_comb begin
      rate_sum = {1'b0, sent_rate_ff} + {1'b0, R_STEP};
      if (drop_total_ff != '0) begin
         if (sent_rate_ff == UNL_R) begin
            new_rate = R_AFTER;
         end else if (sent_rate_ff <= R_STEP) begin
            new_rate = R_FLOOR;
         end else begin
            new_rate = sent_rate_ff - R_STEP;
         end
      end else if (sent_rate_ff == UNL_R) begin
         new_rate = UNL_R;
      end else if (rate_sum > {1'b0, UNL_R}) begin
         new_rate = UNL_R;
      end else begin
         new_rate = rate_sum[RATE_W-1:0];
      end
   end

   assign pub_next = pub_total_ff + {31'd0, have_ff};
   assign fb_due   = (next_fb_ff < now_ff);
   assign notify   = fb_due && (pub_next != '0) && active_ff && (new_rate != sent_rate_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drop_total_in = drop_total_ff;
      pub_total_in  = pub_total_ff;
      next_fb_in    = next_fb_ff;
      sent_rate_in  = sent_rate_ff;
      now_in        = now_ff;
      have_in       = have_ff;
      tag_in        = tag_ff;
      drops_in      = drops_ff;
      note_flags_in = note_flags_ff;
      note_rate_in  = note_rate_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_IDLE;
      rsp_tag_in    = '0;
      rsp_pres_in   = '0;
      rsp_flags_in  = FLAG_NONE;
      rsp_rate_in   = '0;
      rsp_drops_in  = '0;
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  if (enq_ok) begin
                     count_in    = count_ff + 1'b1;
                     rsp_kind_in = KIND_ENQUEUED;
                  end else begin
                     rsp_kind_in = KIND_FULL;
                  end
               end else begin
                  now_in   = req_time_stamp;
                  have_in  = 1'b0;
                  tag_in   = '0;
                  drops_in = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (head_due) begin
               if (have_ff) begin
                  drop_total_in = drop_total_ff + 32'd1;
                  if (drops_ff != 5'd31) begin
                     drops_in = drops_ff + 5'd1;
                  end
               end
               have_in  = 1'b1;
               tag_in   = words[0].tag;
               count_in = count_ff - 1'b1;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            pub_total_in = pub_next;
            if (fb_due) begin
               drop_total_in = '0;
               pub_total_in  = '0;
               next_fb_in    = now_ff + {48'd0, period_ff};
            end
            if (notify) begin
               sent_rate_in = new_rate;
            end
            if (new_rate == UNL_R) begin
               note_flags_in = FLAG_UNLIMITED;
               note_rate_in  = '0;
            end else begin
               note_flags_in = FLAG_LIMITED;
               note_rate_in  = new_rate[4:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (have_ff) begin
               rsp_kind_in  = KIND_SHOW;
               rsp_tag_in   = tag_ff;
               rsp_drops_in = drops_ff;
               rsp_last_in  = !notify;
               if (notify) begin
                  state_in = ST_NOTE;
               end
            end else if (notify) begin
               rsp_kind_in  = KIND_NOTIFY;
               rsp_pres_in  = pres_id_ff;
               rsp_flags_in = note_flags_in;
               rsp_rate_in  = note_rate_in;
               rsp_last_in  = 1'b1;
            end else begin
               rsp_kind_in = KIND_IDLE;
               rsp_last_in = 1'b1;
            end
         end
         ST_NOTE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_NOTIFY;
            rsp_pres_in  = pres_id_ff;
            rsp_flags_in = note_flags_ff;
            rsp_rate_in  = note_rate_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         drop_total_ff <= '0;
         pub_total_ff  <= '0;
         next_fb_ff    <= '0;
         sent_rate_ff  <= UNL_R;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         pres_id_ff    <= '0;
         period_ff     <= PERIOD_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drop_total_ff <= drop_total_in;
         pub_total_ff  <= pub_total_in;
         next_fb_ff    <= next_fb_in;
         sent_rate_ff  <= sent_rate_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ACTIVE: active_ff  <= csr_data[0];
               CSR_ID:     pres_id_ff <= csr_data[7:0];
               CSR_PERIOD: period_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      have_ff       <= have_in;
      tag_ff        <= tag_in;
      drops_ff      <= drops_in;
      note_flags_ff <= note_flags_in;
      note_rate_ff  <= note_rate_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pres_ff   <= rsp_pres_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_drops_ff  <= rsp_drops_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_kind                = rsp_kind_ff;
   assign rsp_shown_tag           = rsp_tag_ff;
   assign rsp_notify_presentation = rsp_pres_ff;
   assign rsp_notify_flags        = rsp_flags_ff;
   assign rsp_desired_rate        = rsp_rate_ff;
   assign rsp_dropped_in_tick     = rsp_drops_ff;
   assign rsp_last                = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_shift_pops: assert property (@(posedge clock) disable iff (reset)
      shift |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue advance did not pop one frame");

   a_note_after_show: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NOTE |-> rsp_valid_ff && rsp_kind_ff == KIND_SHOW && !rsp_last_ff)
      else $error("notification not preceded by a show word");

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      sent_rate_ff <= UNL_R)
      else $error("sent rate above unlimited value");

   a_show_from_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_SHOW |-> $past(state_ff) == ST_EVAL)
      else $error("show word outside tick evaluation");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame pacer with rate feedback.
// ----------------------------------------------------------------------------
// Enqueue and tick words are driven on the start/busy port. A behavioral
// copy of the frame queue, the drop and publish counters and the rate
// feedback loop predicts the result words of each accepted word, and every
// strobed result is compared field by field. A few directed words cover the
// idle tick, a full queue, the largest stamps and deadline wrap. Random
// rounds of enqueue bursts followed by a tick then run under several csr
// settings, with some noise, overflow bursts and late ticks mixed in.
// ----------------------------------------------------------------------------
module tb;
   import fpr_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int UNLIMITED_RATE = 31;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_WORDS    = 150;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] shown_tag;
      logic [7:0] notify_presentation;
      logic [1:0] notify_flags;
      logic [4:0] desired_rate;
      logic [4:0] dropped_in_tick;
      logic       last;
   } pacer_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [63:0] req_time_stamp;
   logic [7:0]  req_frame_tag;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_shown_tag;
   logic [7:0]  rsp_notify_presentation;
   logic [1:0]  rsp_notify_flags;
   logic [4:0]  rsp_desired_rate;
   logic [4:0]  rsp_dropped_in_tick;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   // behavioral state
   logic [63:0] fifo_stamp [QUEUE_DEPTH];
   logic [7:0]  fifo_tag [QUEUE_DEPTH];
   int          fifo_head;
   int          fifo_count;
   logic [31:0] drop_total;
   logic [31:0] pub_total;
   logic [63:0] next_deadline;
   int          sent_rate;
   logic        cfg_active;
   logic [7:0]  cfg_id;
   logic [15:0] cfg_period;

   pacer_result_type due_results[$];
   pacer_result_type want;
   int          fail_count;
   int          cycles;
   int          words_sent;
   logic        no_gaps;
   logic [63:0] sim_now;

   frame_pacer_rate_feedback_top #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .UNLIMITED_RATE(UNLIMITED_RATE)
   ) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_time_stamp         (req_time_stamp),
      .req_frame_tag          (req_frame_tag),
      .rsp_valid              (rsp_valid),
      .rsp_kind               (rsp_kind),
      .rsp_shown_tag          (rsp_shown_tag),
      .rsp_notify_presentation(rsp_notify_presentation),
      .rsp_notify_flags       (rsp_notify_flags),
      .rsp_desired_rate       (rsp_desired_rate),
      .rsp_dropped_in_tick    (rsp_dropped_in_tick),
      .rsp_last               (rsp_last),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("frame_pacer_rate_feedback_top test failed");
         $finish;
      end
   end

   function automatic void pace_word(input logic act, input logic [63:0] stamp,
                                     input logic [7:0] tag);
      pacer_result_type show_word;
      pacer_result_type note_word;
      logic          have;
      logic          note;
      int            drops;
      int            nr;
      show_word = '0;
      note_word = '0;
      have = 1'b0;
      note = 1'b0;
      drops = 0;
      if (act == ACT_ENQUEUE) begin
         if (fifo_count >= QUEUE_DEPTH) begin
            show_word.kind = KIND_FULL;
         end else begin
            fifo_stamp[(fifo_head + fifo_count) % QUEUE_DEPTH] = stamp;
            fifo_tag[(fifo_head + fifo_count) % QUEUE_DEPTH] = tag;
            fifo_count++;
            show_word.kind = KIND_ENQUEUED;
         end
         show_word.last = 1'b1;
         due_results.push_back(show_word);
         return;
      end
      while (fifo_count > 0 && fifo_stamp[fifo_head] <= stamp) begin
         if (have) begin
            drop_total++;
            if (drops < 31) drops++;
         end
         have = 1'b1;
         show_word.shown_tag = fifo_tag[fifo_head];
         fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
         fifo_count--;
      end
      if (have) begin
         pub_total++;
         show_word.kind = KIND_SHOW;
         show_word.dropped_in_tick = 5'(drops);
      end
      if (next_deadline < stamp) begin
         if (pub_total != 0 && cfg_active) begin
            if (drop_total != 0) begin
               if (sent_rate == UNLIMITED_RATE) nr = RATE_AFTER_UNLIMITED;
               else if (sent_rate <= RATE_STEP) nr = RATE_FLOOR;
               else nr = sent_rate - RATE_STEP;
            end else if (sent_rate == UNLIMITED_RATE) begin
               nr = UNLIMITED_RATE;
            end else begin
               nr = sent_rate + RATE_STEP;
               if (nr > UNLIMITED_RATE) nr = UNLIMITED_RATE;
            end
            if (nr != sent_rate) begin
               note = 1'b1;
               note_word.kind = KIND_NOTIFY;
               note_word.notify_presentation = cfg_id;
               note_word.notify_flags = (nr == UNLIMITED_RATE) ? FLAG_UNLIMITED : FLAG_LIMITED;
               note_word.desired_rate = (nr == UNLIMITED_RATE) ? 5'd0 : 5'(nr);
               note_word.last = 1'b1;
               sent_rate = nr;
            end
         end
         drop_total = '0;
         pub_total = '0;
         next_deadline = stamp + 64'(cfg_period);
      end
      if (have) begin
         show_word.last = !note;
         due_results.push_back(show_word);
      end
      if (note) due_results.push_back(note_word);
      if (!have && !note) begin
         show_word = '0;
         show_word.kind = KIND_IDLE;
         show_word.last = 1'b1;
         due_results.push_back(show_word);
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_val,
                                       input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            $error("unexpected result word, kind %0d", rsp_kind);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("shown_tag", want.shown_tag, rsp_shown_tag);
            check_field("notify_presentation", want.notify_presentation,
                        rsp_notify_presentation);
            check_field("notify_flags", 8'(want.notify_flags), 8'(rsp_notify_flags));
            check_field("desired_rate", 8'(want.desired_rate), 8'(rsp_desired_rate));
            check_field("dropped_in_tick", 8'(want.dropped_in_tick),
                        8'(rsp_dropped_in_tick));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   task automatic issue_word(input logic act, input logic [63:0] stamp,
                             input logic [7:0] tag);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_time_stamp <= stamp;
      req_frame_tag <= tag;
      @(posedge clock);
      while (busy) @(posedge clock);
      pace_word(act, stamp, tag);
      words_sent++;
   endtask

   task automatic csr_write(input logic [7:0] index, input logic [15:0] data);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 11) begin
         csr_valid <= 1'b0;
         @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_ACTIVE: cfg_active = data[0];
         CSR_ID:     cfg_id = data[7:0];
         CSR_PERIOD: cfg_period = data;
         default: ;
      endcase
   endtask

   // bits above the active and id registers' widths and an unmapped index are always written too
   task automatic set_config(input logic active, input logic [7:0] id,
                             input logic [15:0] period);
      csr_write(8'($urandom_range(int'(CSR_PERIOD) + 1, 255)), 16'($urandom));
      csr_write(CSR_ACTIVE, {15'($urandom), active});
      csr_write(CSR_ID, {8'($urandom), id});
      csr_write(CSR_PERIOD, period);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic test_idle_tick();
      issue_word(ACT_TICK, 64'd0, 8'hFF);
      wait_idle();
   endtask

   task automatic test_queue_full();
      logic [63:0] stamp;
      logic [7:0]  tag;
      set_config(1'b1, 8'h5A, 16'hFFFF);
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         stamp = 64'($urandom_range(1, 150));
         tag = 8'($urandom);
         if (i == 0) begin
            stamp = '0;
            tag = 8'h00;
         end else if (i == QUEUE_DEPTH - 1) begin
            stamp = '1;
            tag = 8'hFF;
         end
         issue_word(ACT_ENQUEUE, stamp, tag);
      end
      issue_word(ACT_TICK, 64'd200, 8'($urandom));
      issue_word(ACT_TICK, '1, 8'($urandom));
      wait_idle();
   endtask

   task automatic test_paced_rounds();
      logic [7:0]  ids [8];
      logic [15:0] periods [8];
      logic        actives [8];
      int          bursts [8];
      int          target;
      int          pick;
      int          n;
      ids = '{8'($urandom), 8'($urandom), 8'hFF, 8'($urandom), 8'h00, 8'($urandom),
              8'($urandom), 8'($urandom)};
      periods = '{16'd20, 16'd1, 16'd0, 16'd50, 16'hFFFF, 16'd8, 16'd30, 16'd12};
      actives = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      bursts = '{4, 1, 3, 4, 2, 1, 5, 1};
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         set_config(actives[p], ids[p], periods[p]);
         no_gaps = (p == 2);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               n = $urandom_range(0, bursts[p]);
               repeat (n) issue_word(ACT_ENQUEUE, sim_now + 64'($urandom_range(0, 40)),
                                     8'($urandom));
               sim_now = sim_now + 64'($urandom_range(0, 30));
               issue_word(ACT_TICK, sim_now, 8'($urandom));
            end else if (pick < 92) begin
               n = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
               repeat (n) issue_word(ACT_ENQUEUE, sim_now + 64'($urandom_range(0, 60)),
                                     8'($urandom));
               sim_now = sim_now + 64'($urandom_range(0, 30));
               issue_word(ACT_TICK, sim_now, 8'($urandom));
            end else if (periods[p] != 0) begin
               // stray stamp, a late tick, then a flush at the largest time
               issue_word(ACT_ENQUEUE, {$urandom, $urandom}, 8'($urandom));
               issue_word(ACT_TICK, sim_now - 64'($urandom_range(0, 500)), 8'($urandom));
               issue_word(ACT_TICK, '1, 8'($urandom));
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_ENQUEUE;
      req_time_stamp = '0;
      req_frame_tag = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      fail_count = 0;
      cycles = 0;
      words_sent = 0;
      no_gaps = 1'b0;
      sim_now = 64'd100000;
      fifo_head = 0;
      fifo_count = 0;
      drop_total = '0;
      pub_total = '0;
      next_deadline = '0;
      sent_rate = UNLIMITED_RATE;
      cfg_active = 1'b0;
      cfg_id = '0;
      cfg_period = PERIOD_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_tick();
      test_queue_full();
      test_paced_rounds();

      wait_idle();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("frame_pacer_rate_feedback_top test passed");
      end else begin
         $display("frame_pacer_rate_feedback_top test failed");
      end
      $finish;
   end

endmodule

// File: files.f
src/fpr_pkg.sv
src/fpr_cell.sv
src/frame_pacer_rate_feedback_top.sv
tb/tb.sv
